/* hdl/tcw_pkg.sv */
// Package for the text console writer: screen geometry, field widths,
// op codes and the structs passed between the engine and the top level.
// No dependencies.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // cell store address, cursor range 0..CELLS, column counter
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W  = $clog2(CELLS + 1);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CELL_W = 16;
  localparam int CMP_W  = 16;

  // fixed port field widths
  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;

  localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
  localparam logic [OP_W-1:0] OP_NL    = 3'd1;
  localparam logic [OP_W-1:0] OP_BS    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd31;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  character;
    logic [COLOR_W-1:0] color;
    logic               use_default;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_color;
    logic                scrolled;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* hdl/text_console_writer.sv */
// Top level of the text console writer: stream handshakes, default color
// register, output register, cell store RAM. Depends on tcw_pkg,
// tcw_ram and tcw_engine.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata char,color,cell_index; s_tuser op,use_default
//  m_*      out  m_tvalid/m_tready  m_tdata cursor,cell_char,cell_color,scrolled
//  cfg_*    in   cfg_valid/cfg_ready cfg_data default_color
//
// Put char, newline without scroll, backspace, read cell and unused ops are
// accepted, then done in EXEC with one read-modify-write on the store. A
// scroll writes every cell once through the single write port (rows move up,
// last row gets blanks), a put char that scrolls then writes its char in CHAR,
// and clear writes blanks to every cell. After reset a clearing pass zeroes
// all CELLS (2000) cells; no beat is taken meanwhile, cfg writes are. A stalled
// m_* side holds one result and the next beat is still accepted and worked on.
module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // character[7:0], color[15:8], cell_index[26:16], zero pad
  input  logic [3:0]  s_tuser,   // op[2:0], use_default[3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor[10:0], cell_char[18:11], cell_color[26:19],
                                 // scrolled[27], zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // default_color
);

  logic [tcw_pkg::COLOR_W-1:0] default_color;
  tcw_pkg::item_t              item;
  tcw_pkg::ram_req_t           ram_req;
  tcw_pkg::res_t               res;
  logic [tcw_pkg::CELL_W-1:0]  ram_rdata;
  logic                        res_valid;
  logic                        out_free;
  logic                        accept;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    item.character   = s_tdata[7:0];
    item.color       = s_tdata[15:8];
    item.cell_index  = s_tdata[26:16];
    item.op          = s_tuser[2:0];
    item.use_default = s_tuser[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      default_color <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {4'd0, res.scrolled, res.cell_color, res.cell_char, res.cursor};
    end
  end

  tcw_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .in_ready      (s_tready),
    .item          (item),
    .default_color (default_color),
    .ram_req       (ram_req),
    .ram_rdata     (ram_rdata),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .res           (res)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tcw_engine.sv */
// Operation sequencer of the text console writer: cursor and column
// tracking, scroll / clear sweeps over the cell store, result hand-off.
// Depends on tcw_pkg; drives the cell store RAM through a ram_req_t.
module tcw_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcw_pkg::item_t                item,
  input  logic [tcw_pkg::COLOR_W-1:0]   default_color,
  output tcw_pkg::ram_req_t             ram_req,
  input  logic [tcw_pkg::CELL_W-1:0]    ram_rdata,
  input  logic                          out_free,
  output logic                          res_valid,
  output tcw_pkg::res_t                 res
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SCROLL = 6'b000100,
    S_CHAR   = 6'b001000,
    S_FILL   = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  localparam logic [tcw_pkg::IDX_W-1:0] CELLS_IDX = tcw_pkg::IDX_W'(tcw_pkg::CELLS);
  localparam logic [tcw_pkg::IDX_W-1:0] COLS_IDX  = tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::IDX_W-1:0] COPY_END  =
    tcw_pkg::IDX_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::IDX_W-1:0] LAST_IDX  = tcw_pkg::IDX_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::IDX_W:0]   CELLS_WIDE = (tcw_pkg::IDX_W + 1)'(tcw_pkg::CELLS);
  localparam logic [tcw_pkg::IDX_W:0]   COLS_WIDE  = (tcw_pkg::IDX_W + 1)'(tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::COL_W-1:0] COL_LAST  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::CMP_W-1:0] CELLS_CMP = tcw_pkg::CMP_W'(tcw_pkg::CELLS);

  state_t                          state, state_next;
  logic [tcw_pkg::IDX_W-1:0]       cnt, cnt_next;
  logic [tcw_pkg::IDX_W-1:0]       cursor, cursor_next;
  logic [tcw_pkg::COL_W-1:0]       col, col_next;
  logic                            scr, scr_next;
  logic                            pend_char, pend_char_next;
  logic                            fill_zero, fill_zero_next;
  tcw_pkg::item_t                  it;
  logic                            in_rng;
  tcw_pkg::res_t                   hold, res_now;

  logic                            item_rng;
  logic [tcw_pkg::ADDR_W-1:0]      item_addr;
  logic [tcw_pkg::IDX_W:0]         row_next;
  logic [tcw_pkg::IDX_W-1:0]       dst;
  logic [tcw_pkg::CELL_W-1:0]      blank;
  logic                            do_char, fin;
  logic [tcw_pkg::CHAR_W-1:0]      rd_char;
  logic [tcw_pkg::COLOR_W-1:0]     rd_color;

  assign item_rng  = tcw_pkg::CMP_W'(item.cell_index) < CELLS_CMP;
  assign item_addr = item_rng ? tcw_pkg::ADDR_W'(item.cell_index) : '0;
  assign row_next  = {1'b0, cursor} - (tcw_pkg::IDX_W + 1)'(col) + COLS_WIDE;
  assign dst       = cnt - 1'b1;
  assign blank     = {default_color, tcw_pkg::SPACE_CODE};
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cursor_next    = cursor;
    col_next       = col;
    scr_next       = scr;
    pend_char_next = pend_char;
    fill_zero_next = fill_zero;
    ram_req        = '0;
    do_char        = 1'b0;
    fin            = 1'b0;
    res_valid      = 1'b0;
    rd_char        = '0;
    rd_color       = '0;

    case (state)
      S_IDLE: begin
        // read issued in the accept cycle so read data lands in EXEC
        ram_req.raddr = item_addr;
        if (in_valid) begin
          state_next = S_EXEC;
          scr_next   = 1'b0;
        end
      end
      S_EXEC: begin
        case (it.op)
          tcw_pkg::OP_PUT: begin
            if (cursor >= CELLS_IDX) begin
              cursor_next    = cursor - COLS_IDX;
              scr_next       = 1'b1;
              pend_char_next = 1'b1;
              cnt_next       = '0;
              state_next     = S_SCROLL;
            end else begin
              do_char = 1'b1;
            end
          end
          tcw_pkg::OP_NL: begin
            col_next = '0;
            if (row_next >= CELLS_WIDE) begin
              cursor_next    = tcw_pkg::IDX_W'(row_next - COLS_WIDE);
              scr_next       = 1'b1;
              pend_char_next = 1'b0;
              cnt_next       = '0;
              state_next     = S_SCROLL;
            end else begin
              cursor_next = tcw_pkg::IDX_W'(row_next);
              fin         = 1'b1;
            end
          end
          tcw_pkg::OP_BS: begin
            if (cursor != '0) begin
              cursor_next   = cursor - 1'b1;
              col_next      = (col == '0) ? COL_LAST : col - 1'b1;
              ram_req.we    = 1'b1;
              ram_req.waddr = tcw_pkg::ADDR_W'(cursor - 1'b1);
              ram_req.wdata = blank;
            end
            fin = 1'b1;
          end
          tcw_pkg::OP_CLEAR: begin
            cursor_next    = '0;
            col_next       = '0;
            cnt_next       = '0;
            fill_zero_next = 1'b0;
            state_next     = S_FILL;
          end
          tcw_pkg::OP_READ: begin
            if (in_rng) begin
              rd_char  = ram_rdata[tcw_pkg::CHAR_W-1:0];
              rd_color = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            fin = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SCROLL: begin
        // read one row ahead, write the previous cell; last row gets blanks
        if (cnt < COPY_END) begin
          ram_req.raddr = tcw_pkg::ADDR_W'(cnt + COLS_IDX);
        end
        if (cnt != '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = tcw_pkg::ADDR_W'(dst);
          ram_req.wdata = (dst < COPY_END) ? ram_rdata : blank;
        end
        if (cnt == CELLS_IDX) begin
          cnt_next = '0;
          if (pend_char) begin
            state_next = S_CHAR;
          end else begin
            fin = 1'b1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CHAR: begin
        do_char = 1'b1;
      end
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = tcw_pkg::ADDR_W'(cnt);
        ram_req.wdata = fill_zero ? '0 : blank;
        if (cnt == LAST_IDX) begin
          cnt_next = '0;
          if (fill_zero) begin
            fill_zero_next = 1'b0;
            state_next     = S_IDLE;
          end else begin
            fin = 1'b1;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // cursor is below the screen end here
    if (do_char) begin
      if (it.character == tcw_pkg::NEWLINE_CODE) begin
        cursor_next = tcw_pkg::IDX_W'(row_next);
        col_next    = '0;
      end else begin
        ram_req.we    = 1'b1;
        ram_req.waddr = tcw_pkg::ADDR_W'(cursor);
        ram_req.wdata = {(it.use_default ? default_color : it.color), it.character};
        cursor_next   = cursor + 1'b1;
        col_next      = (col == COL_LAST) ? '0 : col + 1'b1;
      end
      fin = 1'b1;
    end

    if (fin) begin
      if (out_free) begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_HOLD;
      end
    end
  end

  always_comb begin
    res_now.cursor     = tcw_pkg::CURSOR_W'(cursor_next);
    res_now.cell_char  = rd_char;
    res_now.cell_color = rd_color;
    res_now.scrolled   = scr_next;
  end

  assign res = (state == S_HOLD) ? hold : res_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      cnt       <= '0;
      cursor    <= '0;
      col       <= '0;
      scr       <= 1'b0;
      pend_char <= 1'b0;
      fill_zero <= 1'b1;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      cursor    <= cursor_next;
      col       <= col_next;
      scr       <= scr_next;
      pend_char <= pend_char_next;
      fill_zero <= fill_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it     <= item;
      in_rng <= item_rng;
    end
    if (fin) begin
      hold <= res_now;
    end
  end

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result handed over while output register is full");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (tcw_pkg::CMP_W'(ram_req.waddr) < CELLS_CMP))
    else $error("cell store write beyond screen");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CELLS_IDX)
    else $error("cursor beyond screen end");

  a_boot_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && fill_zero) |-> !res_valid && !in_ready)
    else $error("activity during reset clearing pass");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

endmodule
